### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the dual stack RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define DSTK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dual stack assertion failed");

// Implication checked in the cycle after the antecedent holds.
`define DSTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dual stack assertion failed");

`else

`define DSTK_ASSERT(lbl, clk, rst_n, prop)
`define DSTK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/dstk_pkg.sv
// ----------------------------------------------------------------------------
// Dual stack package
// Sizes, command and status codes, and the view type of one stack.
// ----------------------------------------------------------------------------
`default_nettype none

package dstk_pkg;

  // Number of entries each stack can hold.
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths of the stream items.
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned IN_RAW_W  = CMD_W + VALUE_W;
  localparam int unsigned IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_RAW_W = STATUS_W + 2 * (VALUE_W + DEPTH_W);
  localparam int unsigned OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH        = 2'd0,
    CMD_POP         = 2'd1,
    CMD_MAIN_TO_AUX = 2'd2,
    CMD_AUX_TO_MAIN = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Operation applied to one stack in a cycle; never both at once.
  typedef struct packed {
    logic push;
    logic pop;
  } dstk_op_t;

  // Current state of one stack as seen before the operation.
  typedef struct packed {
    logic [VALUE_W-1:0] top;
    logic [CNT_W-1:0]   count;
    logic               empty;
    logic               full;
  } dstk_view_t;

endpackage

`default_nettype wire

### rtl/dstk_stack.sv
// ----------------------------------------------------------------------------
// Shift-register stack
// One bounded LIFO whose top always sits in entry zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dstk_stack
  import dstk_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dstk_op_t           op_i,
  input  wire logic [VALUE_W-1:0] data_i,
  output dstk_view_t              cur_o,
  output logic [VALUE_W-1:0]      nxt_top_o,
  output logic [CNT_W-1:0]        nxt_count_o
);

  localparam int unsigned SecIdx = (STACK_DEPTH > 1) ? 1 : 0;

  logic [VALUE_W-1:0] ent_q [STACK_DEPTH];
  logic [VALUE_W-1:0] ent_d [STACK_DEPTH];
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   cnt_d;

  // Push shifts every entry one place down, pop one place up.
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      ent_d[i] = ent_q[i];
      if (op_i.push) begin
        ent_d[i] = (i == 0) ? data_i : ent_q[(i == 0) ? 0 : i - 1];
      end else if (op_i.pop && (i < STACK_DEPTH - 1)) begin
        ent_d[i] = ent_q[(i < STACK_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    cnt_d     = cnt_q;
    nxt_top_o = (cnt_q != '0) ? ent_q[0] : '0;
    if (op_i.push) begin
      cnt_d     = cnt_q + CNT_W'(1);
      nxt_top_o = data_i;
    end else if (op_i.pop) begin
      cnt_d     = cnt_q - CNT_W'(1);
      nxt_top_o = (cnt_q > CNT_W'(1)) ? ent_q[SecIdx] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.push || op_i.pop) begin
      ent_q <= ent_d;
    end
  end

  assign nxt_count_o = cnt_d;
  assign cur_o.top   = ent_q[0];
  assign cur_o.count = cnt_q;
  assign cur_o.empty = (cnt_q == '0);
  assign cur_o.full  = (cnt_q == CNT_W'(STACK_DEPTH));

endmodule

`default_nettype wire

### rtl/dual_stack_with_transfer.sv
// ----------------------------------------------------------------------------
// Dual stack with transfer
// Main and auxiliary LIFO stacks with push, pop and moves between them.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Bus          Contents (lowest bits first)
//   s_axis    in         tdata[39:0]  cmd, push_value, zero pad
//   m_axis    out        tdata[79:0]  status, main_top, main_depth,
//                                     aux_top, aux_depth, zero pad
//
// Each request is executed in the cycle it is accepted, and its result
// appears in the output register on the next cycle. A new request can be
// accepted every cycle; the limit is the single update of the two
// shift-register stacks per clock. When the result register is full and
// the downstream stalls, s_axis_tready_o drops until the result leaves.
// Reset empties both stacks and the result register; stored entries are
// not cleared, since only entries below a count are ever shown.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dual_stack_with_transfer
  import dstk_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Request channel.
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [1:0] cmd, [33:2] push_value, [39:34] zero.
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,
  // Result channel.
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // [1:0] status, [33:2] main_top, [38:34] main_depth,
  // [70:39] aux_top, [75:71] aux_depth, [79:76] zero.
  output logic [OUT_W-1:0]      m_axis_tdata_o
);

  // Request fields.
  cmd_e               in_cmd;
  logic [VALUE_W-1:0] in_value;
  logic               in_acc;

  assign in_cmd   = cmd_e'(s_axis_tdata_i[CMD_W-1:0]);
  assign in_value = s_axis_tdata_i[CMD_W +: VALUE_W];
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  // Stack instances.
  dstk_op_t           main_op;
  dstk_op_t           aux_op;
  logic [VALUE_W-1:0] main_data;
  logic [VALUE_W-1:0] aux_data;
  dstk_view_t         main_cur;
  dstk_view_t         aux_cur;
  logic [VALUE_W-1:0] main_nxt_top;
  logic [VALUE_W-1:0] aux_nxt_top;
  logic [CNT_W-1:0]   main_nxt_cnt;
  logic [CNT_W-1:0]   aux_nxt_cnt;
  status_e            status;

  dstk_stack u_main (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (main_op),
    .data_i      (main_data),
    .cur_o       (main_cur),
    .nxt_top_o   (main_nxt_top),
    .nxt_count_o (main_nxt_cnt)
  );

  dstk_stack u_aux (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (aux_op),
    .data_i      (aux_data),
    .cur_o       (aux_cur),
    .nxt_top_o   (aux_nxt_top),
    .nxt_count_o (aux_nxt_cnt)
  );

  // Command decode. The source is checked for empty before the
  // destination is checked for full; a refused command leaves both
  // stacks untouched. Operations are only issued on an accepted request.
  always_comb begin
    main_op   = '0;
    aux_op    = '0;
    status    = ST_DONE;
    main_data = (in_cmd == CMD_PUSH) ? in_value : aux_cur.top;
    aux_data  = main_cur.top;
    case (in_cmd)
      CMD_PUSH: begin
        if (main_cur.full) begin
          status = ST_FULL;
        end else begin
          main_op.push = in_acc;
        end
      end
      CMD_POP: begin
        if (main_cur.empty) begin
          status = ST_EMPTY;
        end else begin
          main_op.pop = in_acc;
        end
      end
      CMD_MAIN_TO_AUX: begin
        if (main_cur.empty) begin
          status = ST_EMPTY;
        end else if (aux_cur.full) begin
          status = ST_FULL;
        end else begin
          main_op.pop = in_acc;
          aux_op.push = in_acc;
        end
      end
      CMD_AUX_TO_MAIN: begin
        if (aux_cur.empty) begin
          status = ST_EMPTY;
        end else if (main_cur.full) begin
          status = ST_FULL;
        end else begin
          aux_op.pop   = in_acc;
          main_op.push = in_acc;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  // Result register. It loads whenever a request is accepted, which is
  // allowed when it is empty or its current result leaves this cycle.
  logic                 out_vld_q;
  logic [OUT_RAW_W-1:0] out_q;
  logic [OUT_RAW_W-1:0] out_d;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;

  // The shown depth is the stack count in the depth field's width.
  assign out_d = {DEPTH_W'(aux_nxt_cnt), aux_nxt_top,
                  DEPTH_W'(main_nxt_cnt), main_nxt_top, status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {(OUT_W - OUT_RAW_W)'(0), out_q};

  // Checks on the stack bookkeeping.
  logic [CNT_W:0]     total_cnt;
  logic               is_move;
  logic               move_acc;
  logic               depth_ok;
  logic               pop_on_empty;
  logic [2*CNT_W-1:0] both_cnt;
  status_e            out_status;

  assign total_cnt    = {1'b0, main_cur.count} + {1'b0, aux_cur.count};
  assign is_move      = (in_cmd == CMD_MAIN_TO_AUX) || (in_cmd == CMD_AUX_TO_MAIN);
  assign move_acc     = in_acc && is_move;
  assign depth_ok     = (main_cur.count <= CNT_W'(STACK_DEPTH)) &&
                        (aux_cur.count <= CNT_W'(STACK_DEPTH));
  assign pop_on_empty = in_acc && (in_cmd == CMD_POP) && main_cur.empty;
  assign both_cnt     = {main_cur.count, aux_cur.count};
  assign out_status   = status_e'(out_q[STATUS_W-1:0]);

  `DSTK_ASSERT(a_depth_bound, clk_i, rst_ni, depth_ok)
  `DSTK_ASSERT_NEXT(a_move_keeps_total, clk_i, rst_ni, move_acc, total_cnt == $past(total_cnt))
  `DSTK_ASSERT_NEXT(a_idle_holds_counts, clk_i, rst_ni, !in_acc, $stable(both_cnt))
  `DSTK_ASSERT_NEXT(a_pop_empty_status, clk_i, rst_ni, pop_on_empty, out_status == ST_EMPTY)

endmodule

`default_nettype wire

### tb/sv/tb_dual_stack_with_transfer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual stack with transfer testbench
// Sends push, pop and move requests to the main and auxiliary stacks and
// checks every result against a behavioral copy of both stacks. A short
// directed part covers empty stacks, value extremes and transfers. Random
// walks with fill and drain bias then drive both stacks into their full
// and empty corners, with idle cycles on both sides first and back-to-back
// traffic at the end.
// ----------------------------------------------------------------------------

module tb_dual_stack_with_transfer;
  import dstk_pkg::*;

  localparam int unsigned PAD_W      = OUT_W - OUT_RAW_W;
  localparam int unsigned MAX_PRINTS = 100;

  // Result bus layout, lowest field in the last member.
  typedef struct packed {
    logic [PAD_W-1:0]   pad;
    logic [DEPTH_W-1:0] aux_depth;
    logic [VALUE_W-1:0] aux_top;
    logic [DEPTH_W-1:0] main_depth;
    logic [VALUE_W-1:0] main_top;
    status_e            status;
  } stack_report_t;

  // Command mix of one random stretch.
  typedef enum int {
    WALK_FILL,
    WALK_DRAIN,
    WALK_MIX
  } walk_e;

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            s_axis_tvalid_i = 1'b0;
  logic            s_axis_tready_o;
  // [1:0] cmd, [33:2] push_value, [39:34] zero.
  logic [IN_W-1:0] s_axis_tdata_i  = '0;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i = 1'b0;
  // [1:0] status, [33:2] main_top, [38:34] main_depth,
  // [70:39] aux_top, [75:71] aux_depth, [79:76] zero.
  logic [OUT_W-1:0] m_axis_tdata_o;

  dual_stack_with_transfer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Behavioral copy of both stacks and the results still owed by the block.
  logic [VALUE_W-1:0] main_image [STACK_DEPTH];
  logic [VALUE_W-1:0] aux_image  [STACK_DEPTH];
  int unsigned        main_fill = 0;
  int unsigned        aux_fill  = 0;
  stack_report_t      pending_reports [$];

  int unsigned mismatch_count = 0;
  int unsigned result_index   = 0;
  bit          idle_on        = 1'b1;
  int unsigned stall_left     = 0;

  // Applies one request to the stack copy and returns the result it owes.
  // An empty source wins over a full destination on a move.
  function automatic stack_report_t apply_command(input cmd_e cmd,
                                                  input logic [VALUE_W-1:0] value);
    stack_report_t rep;
    rep        = '0;
    rep.status = ST_DONE;
    case (cmd)
      CMD_PUSH: begin
        if (main_fill >= STACK_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          main_image[main_fill] = value;
          main_fill++;
        end
      end
      CMD_POP: begin
        if (main_fill == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          main_fill--;
        end
      end
      CMD_MAIN_TO_AUX: begin
        if (main_fill == 0) begin
          rep.status = ST_EMPTY;
        end else if (aux_fill >= STACK_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          aux_image[aux_fill] = main_image[main_fill - 1];
          aux_fill++;
          main_fill--;
        end
      end
      default: begin
        if (aux_fill == 0) begin
          rep.status = ST_EMPTY;
        end else if (main_fill >= STACK_DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          main_image[main_fill] = aux_image[aux_fill - 1];
          main_fill++;
          aux_fill--;
        end
      end
    endcase
    // An empty stack shows a zero top.
    rep.main_top   = (main_fill == 0) ? '0 : main_image[main_fill - 1];
    rep.main_depth = main_fill[DEPTH_W-1:0];
    rep.aux_top    = (aux_fill == 0) ? '0 : aux_image[aux_fill - 1];
    rep.aux_depth  = aux_fill[DEPTH_W-1:0];
    return rep;
  endfunction

  // Prints one line per mismatch, up to a cap, and counts all of them.
  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] result %0d: bad %s, got 0x%08h, want 0x%08h",
               $realtime, result_index, what, got, want);
    end
    mismatch_count++;
  endtask

  // Sends one request, with an optional idle burst ahead of it, and records
  // the expected result once the block has accepted it.
  task automatic send_request(input cmd_e cmd, input logic [VALUE_W-1:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= IN_W'({value, cmd});
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_reports.push_back(apply_command(cmd, value));
  endtask

  // Holds the sender off until every owed result has come back.
  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // Picks a command with a weighting that pushes the stacks toward full,
  // toward empty, or keeps them wandering.
  function automatic cmd_e pick_command(input walk_e mode);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mode)
      WALK_FILL: begin
        if (roll < 50) return CMD_PUSH;
        if (roll < 85) return CMD_MAIN_TO_AUX;
        if (roll < 95) return CMD_AUX_TO_MAIN;
        return CMD_POP;
      end
      WALK_DRAIN: begin
        if (roll < 10) return CMD_PUSH;
        if (roll < 45) return CMD_POP;
        if (roll < 70) return CMD_MAIN_TO_AUX;
        return CMD_AUX_TO_MAIN;
      end
      default: return cmd_e'(roll[1:0]);
    endcase
  endfunction

  // Mostly random words, with the sign and range corners mixed in.
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Every command on two empty stacks must report an empty source,
  // except a push.
  task automatic test_empty_stacks();
    send_request(CMD_POP, $urandom);
    send_request(CMD_MAIN_TO_AUX, $urandom);
    send_request(CMD_AUX_TO_MAIN, $urandom);
  endtask

  // The extremes of the signed value range pass through the stacks intact.
  task automatic test_value_extremes();
    send_request(CMD_PUSH, 32'h8000_0000);
    send_request(CMD_PUSH, 32'h7FFF_FFFF);
    send_request(CMD_PUSH, 32'h0000_0000);
    send_request(CMD_PUSH, 32'hFFFF_FFFF);
    send_request(CMD_PUSH, 32'h0000_0001);
    send_request(CMD_POP, 32'hFFFF_FFFF);
  endtask

  // Moves in both directions, then both stacks run dry one after the other.
  task automatic test_transfers();
    send_request(CMD_MAIN_TO_AUX, $urandom);
    send_request(CMD_MAIN_TO_AUX, $urandom);
    send_request(CMD_AUX_TO_MAIN, $urandom);
    send_request(CMD_MAIN_TO_AUX, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_AUX_TO_MAIN, $urandom);
    send_request(CMD_AUX_TO_MAIN, $urandom);
    send_request(CMD_AUX_TO_MAIN, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_POP, $urandom);
    send_request(CMD_POP, $urandom);
  endtask

  // Random stretches of 16 to 48 requests, each with its own command mix.
  // Fill stretches drive both stacks to full, so overflow on a push, on
  // either move, and a move from an empty stack into a full one all occur.
  task automatic test_random_walk(input int unsigned num_items);
    int unsigned sent;
    int unsigned stretch;
    walk_e       mode;
    sent = 0;
    while (sent < num_items) begin
      mode    = walk_e'($urandom_range(0, 2));
      stretch = $urandom_range(16, 48);
      repeat (stretch) begin
        send_request(pick_command(mode), pick_value());
        sent++;
      end
    end
  endtask

  // The last stretch runs with no idle cycles on either side.
  task automatic test_back_to_back(input int unsigned num_items);
    idle_on = 1'b0;
    test_random_walk(num_items);
  endtask

  // Receiver stalls come in bursts of random length while idle cycles are enabled.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left      <= $urandom_range(0, 3);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Compares each accepted result with the oldest one owed.
  always @(posedge clk_i) begin : check_results
    stack_report_t got;
    stack_report_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (pending_reports.size() == 0) begin
        report_mismatch("unrequested result", got.main_top, '0);
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", VALUE_W'(got.status), VALUE_W'(want.status));
        if (got.main_top !== want.main_top)
          report_mismatch("main_top", got.main_top, want.main_top);
        if (got.main_depth !== want.main_depth)
          report_mismatch("main_depth", VALUE_W'(got.main_depth), VALUE_W'(want.main_depth));
        if (got.aux_top !== want.aux_top)
          report_mismatch("aux_top", got.aux_top, want.aux_top);
        if (got.aux_depth !== want.aux_depth)
          report_mismatch("aux_depth", VALUE_W'(got.aux_depth), VALUE_W'(want.aux_depth));
        if (got.pad !== want.pad)
          report_mismatch("padding", VALUE_W'(got.pad), VALUE_W'(want.pad));
      end
      result_index++;
    end
  end

  initial begin : run_tests
    int unsigned drain_cycles;
    drain_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stacks();
    test_value_extremes();
    test_transfers();
    // Let the pipeline empty completely before random traffic starts.
    wait_for_results();
    test_random_walk(500);
    wait_for_results();
    test_random_walk(550);
    test_back_to_back(180);

    // Wait for the last results, then keep watching for strays.
    s_axis_tvalid_i <= 1'b0;
    while (pending_reports.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_reports.size() != 0)
      report_mismatch("missing results", VALUE_W'(pending_reports.size()), '0);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
